// ----- hdl/rmb_pkg.sv -----
// Shared types, constants and helpers for the run-length mono image blitter.
// Used by rmb_frame_rmw and rle_mono_image_blit; depends on nothing else.
package rmb_pkg;

    localparam logic [11:0] ROW_MAX   = 12'hFFF;
    localparam logic [17:0] COUNT_MAX = 18'h3FFFF;
    localparam logic [3:0]  NIBBLE_ON = 4'hA;

    localparam logic       KIND_COUNT = 1'b0;
    localparam logic       KIND_READ  = 1'b1;
    localparam logic       MODE_RUN   = 1'b0;
    localparam logic       MODE_READ  = 1'b1;

    localparam logic [1:0] REG_ORIGIN_X    = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y    = 2'd1;
    localparam logic [1:0] REG_IMAGE_WIDTH = 2'd2;
    localparam logic [1:0] REG_OVERWRITE   = 2'd3;

    typedef struct packed {
        logic        mode;
        logic [7:0]  run_length;
        logic        last_run;
        logic [14:0] read_index;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [17:0] visible_count;
        logic [31:0] pixel_word;
    } t_out_item;

    // One framebuffer access: a byte read for the output, or a masked update.
    typedef struct packed {
        logic       valid;
        logic       is_read;
        logic       zero;
        logic       set_bits;
        logic [7:0] mask;
    } t_mem_req;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_rd_resp;

    // Bit k of the byte lights nibble k^1 of the panel word.
    function automatic logic [31:0] expand_byte(input logic [7:0] b);
        logic [31:0] w;
        w = '0;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                w[4 * (k ^ 1) +: 4] = NIBBLE_ON;
            end
        end
        return w;
    endfunction

endpackage

// ----- hdl/rmb_frame_rmw.sv -----
// Framebuffer memory with its read-modify-write stage, forwarding and clearing pass.
// Depends on rmb_pkg.
module rmb_frame_rmw import rmb_pkg::*; #(
    parameter int DEPTH  = 19200,
    parameter int ADDR_W = 15
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mem_req          i_req,
    input  logic [ADDR_W-1:0] i_addr,
    output t_rd_resp          o_resp,
    output logic              o_clearing
);

    logic [7:0] mem [DEPTH];

    logic [7:0]        r_rdata;
    logic              r_b_valid;
    logic              r_b_read;
    logic              r_b_zero;
    logic              r_b_on;
    logic [7:0]        r_b_mask;
    logic [ADDR_W-1:0] r_b_addr;
    logic              r_w_valid;
    logic [ADDR_W-1:0] r_w_addr;
    logic [7:0]        r_w_data;
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;

    logic [7:0]        cur;
    logic [7:0]        n_data;
    logic              b_write;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;

    // The byte written in the previous cycle is not yet visible in r_rdata.
    assign cur     = (r_w_valid && r_w_addr == r_b_addr) ? r_w_data : r_rdata;
    assign n_data  = r_b_on ? (cur | r_b_mask) : (cur & ~r_b_mask);
    assign b_write = r_b_valid && !r_b_read;
    assign we      = r_clearing || b_write;
    assign waddr   = r_clearing ? r_clr_addr : r_b_addr;
    assign wdata   = r_clearing ? 8'h00 : n_data;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid  <= 1'b0;
            r_w_valid  <= 1'b0;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_b_valid <= i_req.valid;
            r_w_valid <= b_write;
            if (r_clearing) begin
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_read <= i_req.is_read;
        r_b_zero <= i_req.zero;
        r_b_on   <= i_req.set_bits;
        r_b_mask <= i_req.mask;
        r_b_addr <= i_addr;
        r_w_addr <= r_b_addr;
        r_w_data <= n_data;
    end

    assign o_resp.valid = r_b_valid && r_b_read;
    assign o_resp.data  = r_b_zero ? 8'h00 : cur;
    assign o_clearing   = r_clearing;

endmodule

// ----- hdl/rle_mono_image_blit.sv -----
// Run-length 1-bit image blitter into a bit-packed framebuffer.
//
// Input channel (i_in_valid / o_in_ready, i_in_data): mode 0 carries one run
// byte; runs alternate off and on, starting with off. A run with last_run set
// is drawn, then yields a count result and starts a new image. Mode 1 reads
// one framebuffer byte and returns it expanded to the 32-bit panel pattern.
// Output channel (o_out_valid / i_out_ready, o_out_data) holds one result in
// a register; the next request is accepted while that result waits.
// Configuration (i_cfg_we, i_cfg_index, i_cfg_data) must be written by the
// user between items; the block itself does not enforce this.
// A run of n pixels passes through an accept step, a setup step, its segments
// in turn and a closing step. A segment stays within one image row and one
// visible or hidden stretch of that row, and a visible segment also within
// one framebuffer byte: a wide image needs about n/8 + 1 segments, while a
// one-pixel-wide image needs n. A last run then loads its count into the
// output register. A read issues its byte request, then loads the expanded
// byte. The rate is set by the single read-modify-write byte port of the
// framebuffer memory. After reset the framebuffer is cleared one byte per
// cycle over its ceil(SCREEN_WIDTH * SCREEN_HEIGHT / 8) bytes (19200 at the
// default size); no request is accepted until then. A stalled receiver holds
// a finished result, and the next result waits for the register to empty.
module rle_mono_image_blit import rmb_pkg::*; #(
    parameter int SCREEN_WIDTH  = 480,
    parameter int SCREEN_HEIGHT = 320
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data
);

    localparam int FB_BYTES = (SCREEN_WIDTH * SCREEN_HEIGHT + 7) / 8;
    localparam int ADDR_W   = (FB_BYTES > 1) ? $clog2(FB_BYTES) : 1;
    localparam int BASE_W   = $clog2(SCREEN_WIDTH * 4608);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_SETUP     = 3'd1;
    localparam logic [2:0] S_RUN       = 3'd2;
    localparam logic [2:0] S_FINISH    = 3'd3;
    localparam logic [2:0] S_READ      = 3'd4;
    localparam logic [2:0] S_READ_WAIT = 3'd5;

    logic [2:0]        r_state;
    logic [8:0]        r_origin_x;
    logic [8:0]        r_origin_y;
    logic [11:0]       r_image_width;
    logic              r_overwrite;
    logic [11:0]       r_col;
    logic [11:0]       r_row;
    logic              r_parity;
    logic [17:0]       r_total;
    logic [BASE_W-1:0] r_base;
    logic [7:0]        r_rem;
    logic              r_last;
    logic [14:0]       r_read_index;
    logic              r_out_valid;
    t_out_item         r_out;

    t_mem_req          req;
    logic [ADDR_W-1:0] req_addr;
    t_rd_resp          resp;
    logic              clearing;

    logic [12:0]       width13;
    logic [12:0]       sx;
    logic [12:0]       sy;
    logic [12:0]       rem_w;
    logic [12:0]       lim_s;
    logic [12:0]       seg;
    logic [7:0]        n;
    logic              on_screen;
    logic [BASE_W-1:0] pos;
    logic              wrap;
    logic [18:0]       sum;
    logic [7:0]        mask;
    logic              out_free;
    logic              out_load;
    logic              read_ok;

    rmb_frame_rmw #(
        .DEPTH  (FB_BYTES),
        .ADDR_W (ADDR_W)
    ) u_frame (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req),
        .i_addr     (req_addr),
        .o_resp     (resp),
        .o_clearing (clearing)
    );

    assign o_in_ready = (r_state == S_IDLE) && !clearing;
    assign out_free   = !r_out_valid || i_out_ready;
    assign out_load   = (r_state == S_FINISH && out_free) ||
                        (r_state == S_READ_WAIT && resp.valid);
    assign read_ok    = {17'd0, r_read_index} < 32'(FB_BYTES);

    // Segment of the run handled this cycle: it stays within one image row and
    // one visibility class, and a visible segment also within one byte.
    always_comb begin
        width13   = (r_image_width == 12'd0) ? 13'd4096 : {1'b0, r_image_width};
        sx        = {4'd0, r_origin_x} + {1'b0, r_col};
        sy        = {4'd0, r_origin_y} + {1'b0, r_row};
        on_screen = (sx < 13'(SCREEN_WIDTH)) && (sy < 13'(SCREEN_HEIGHT));
        rem_w     = ({1'b0, r_col} + 13'd1 >= width13) ? 13'd1 : width13 - {1'b0, r_col};
        lim_s     = 13'(SCREEN_WIDTH) - sx;
        pos       = r_base + BASE_W'(sx);
        seg       = {5'd0, r_rem};
        if (rem_w < seg) begin
            seg = rem_w;
        end
        if (on_screen) begin
            if (lim_s < seg) begin
                seg = lim_s;
            end
            if (13'd8 - {10'd0, pos[2:0]} < seg) begin
                seg = 13'd8 - {10'd0, pos[2:0]};
            end
        end
        n    = seg[7:0];
        wrap = (seg == rem_w);
        sum  = {1'b0, r_total} + {11'd0, n};
        mask = (~(8'hFF << n[3:0])) << pos[2:0];
    end

    always_comb begin
        req      = '0;
        req_addr = '0;
        if (r_state == S_RUN && r_rem != 8'd0 && on_screen && (r_parity || r_overwrite)) begin
            req.valid    = 1'b1;
            req.set_bits = r_parity;
            req.mask     = mask;
            req_addr     = ADDR_W'(pos[BASE_W-1:3]);
        end else if (r_state == S_READ && out_free) begin
            req.valid   = 1'b1;
            req.is_read = 1'b1;
            req.zero    = !read_ok;
            req_addr    = read_ok ? ADDR_W'(r_read_index) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_origin_x    <= 9'd0;
            r_origin_y    <= 9'd0;
            r_image_width <= 12'd1;
            r_overwrite   <= 1'b0;
            r_col         <= 12'd0;
            r_row         <= 12'd0;
            r_parity      <= 1'b0;
            r_total       <= 18'd0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_ORIGIN_X:    r_origin_x    <= i_cfg_data[8:0];
                    REG_ORIGIN_Y:    r_origin_y    <= i_cfg_data[8:0];
                    REG_IMAGE_WIDTH: r_image_width <= i_cfg_data;
                    REG_OVERWRITE:   r_overwrite   <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (r_out_valid && i_out_ready && !out_load) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_state <= (i_in_data.mode == MODE_READ) ? S_READ : S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (r_rem == 8'd0) begin
                        r_parity <= !r_parity;
                        r_state  <= r_last ? S_FINISH : S_IDLE;
                    end else begin
                        if (on_screen) begin
                            r_total <= (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[17:0];
                        end
                        if (wrap) begin
                            r_col <= 12'd0;
                            if (r_row != ROW_MAX) begin
                                r_row <= r_row + 12'd1;
                            end
                        end else begin
                            r_col <= r_col + {4'd0, n};
                        end
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_col       <= 12'd0;
                        r_row       <= 12'd0;
                        r_parity    <= 1'b0;
                        r_total     <= 18'd0;
                        r_state     <= S_IDLE;
                    end
                end
                S_READ: begin
                    if (out_free) begin
                        r_state <= S_READ_WAIT;
                    end
                end
                S_READ_WAIT: begin
                    if (resp.valid) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid && o_in_ready) begin
            r_rem        <= i_in_data.run_length;
            r_last       <= i_in_data.last_run;
            r_read_index <= i_in_data.read_index;
        end else if (r_state == S_RUN && r_rem != 8'd0) begin
            r_rem <= r_rem - n;
        end
        if (r_state == S_SETUP) begin
            r_base <= BASE_W'(sy * SCREEN_WIDTH);
        end else if (r_state == S_RUN && r_rem != 8'd0 && wrap && r_row != ROW_MAX) begin
            r_base <= r_base + BASE_W'(SCREEN_WIDTH);
        end
        if (r_state == S_FINISH && out_free) begin
            r_out.result_kind   <= KIND_COUNT;
            r_out.visible_count <= r_total;
            r_out.pixel_word    <= 32'd0;
        end else if (r_state == S_READ_WAIT && resp.valid) begin
            r_out.result_kind   <= KIND_READ;
            r_out.visible_count <= 18'd0;
            r_out.pixel_word    <= expand_byte(resp.data);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_read_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req.valid && req.is_read) |-> out_free)
        else $error("framebuffer read issued with the output register full");

    a_resp_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        resp.valid |-> $past(req.valid && req.is_read))
        else $error("read response without a read one cycle earlier");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !o_in_ready)
        else $error("request accepted during the clearing pass");

    a_write_only_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req.valid && !req.is_read) |-> (r_state == S_RUN && !clearing))
        else $error("framebuffer update outside run decoding");

endmodule
